[hdl/oaht_pkg.sv]
// Shared widths, codes and controller/datapath handshake types of the hash table.
`timescale 1ns / 1ps

package oaht_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_ID_W = 32;
   localparam int HASH_W   = 32;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int MARK_W   = 2;
   localparam int LIMIT_W  = 8;
   localparam int USED_W   = 9;

   localparam logic [OP_W-1:0] OP_GET   = 2'd0;
   localparam logic [OP_W-1:0] OP_SET   = 2'd1;
   localparam logic [OP_W-1:0] OP_DEL   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

   typedef struct packed {
      logic capture;
      logic mod_mul;
      logic mod_sub;
      logic probe;
      logic sweep;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_clear;
      logic probe_done;
      logic sweep_done;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

[hdl/oaht_if.sv]
// Request and response channel interfaces of the hash table.
`timescale 1ns / 1ps

interface oaht_req_if import oaht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [KEY_ID_W-1:0] key_id;
   logic [HASH_W-1:0]   key_hash;
   logic [VALUE_W-1:0]  value_in;

   modport source (output valid, output operation, output key_id, output key_hash,
                   output value_in, input ready);
   modport sink   (input valid, input operation, input key_id, input key_hash,
                   input value_in, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [VALUE_W-1:0]  value_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output hit, output value_out, output status, input ready);
   modport sink   (input valid, input hit, input value_out, input status, output ready);
endinterface

[hdl/oaht_ctrl.sv]
// Controller state machine that sequences hashing, probing, clearing and the response.
`timescale 1ns / 1ps

module oaht_ctrl import oaht_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] S_WIPE    = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_MOD_MUL = 3'd2;
   localparam logic [2:0] S_MOD_SUB = 3'd3;
   localparam logic [2:0] S_PROBE   = 3'd4;
   localparam logic [2:0] S_CLEAR   = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_WIPE: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_clear ? S_CLEAR : S_MOD_MUL;
            end
         end
         S_MOD_MUL: begin
            cmd.mod_mul = 1'b1;
            state_in    = S_MOD_SUB;
         end
         S_MOD_SUB: begin
            cmd.mod_sub = 1'b1;
            state_in    = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.probe_done) state_in = S_FINISH;
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_WIPE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/oaht_datapath.sv]
// Datapath with the slot memory, hash reduction, probe evaluation and response register.
`timescale 1ns / 1ps

module oaht_datapath import oaht_pkg::*; #(
   parameter int TABLE_SLOTS = 256,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [KEY_ID_W-1:0] req_key_id,
   input  logic [HASH_W-1:0]   req_key_hash,
   input  logic [VALUE_W-1:0]  req_value_in,
   oaht_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data,
   input  ctrl_cmd_type        cmd,
   output ctrl_sts_type        sts
);

   localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
   localparam int KW      = (KEY_BITS < KEY_ID_W) ? KEY_BITS : KEY_ID_W;
   localparam int SHIFT   = HASH_W + $clog2(TABLE_SLOTS);
   localparam int PROD_W  = 2 * HASH_W + 1;
   localparam int ENTRY_W = MARK_W + KW + VALUE_BITS;
   localparam logic [63:0] RECIP =
      ((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(TABLE_SLOTS - 1);
   localparam logic [HASH_W-1:0] SLOTS_H  = HASH_W'(TABLE_SLOTS);

   logic [ENTRY_W-1:0] mem [TABLE_SLOTS];

   logic [OP_W-1:0]       op_ff;
   logic [KW-1:0]         key_ff;
   logic [HASH_W-1:0]     hash_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [IDX_W-1:0]      addr_ff;
   logic [IDX_W-1:0]      addr_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  rd_valid_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  have_tomb_ff;
   logic [IDX_W-1:0]      tomb_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      slot_ff;
   logic [MARK_W-1:0]     kind_ff;
   logic [VALUE_BITS-1:0] hit_val_ff;
   logic [USED_W-1:0]     used_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic [HASH_W-1:0]     quot;
   logic [HASH_W-1:0]     quot_n;
   logic [HASH_W-1:0]     rem;
   logic [MARK_W-1:0]     rd_mark;
   logic [KW-1:0]         rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  eval;
   logic                  is_empty;
   logic                  is_match;
   logic                  is_tomb;
   logic                  probe_done;
   logic                  sweep_done;
   logic                  rsp_free;
   logic                  fin_go;
   logic                  res_hit;
   logic [VALUE_W-1:0]    res_value;
   logic [STATUS_W-1:0]   res_status;
   logic                  res_wr;
   logic [MARK_W-1:0]     res_mark;
   logic                  res_bump;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   logic [ENTRY_W-1:0]    mem_wd;

   // Slot index is key_hash mod TABLE_SLOTS by reciprocal multiply and one back-multiply.
   assign quot   = HASH_W'(prod_ff >> SHIFT);
   assign quot_n = HASH_W'(quot * SLOTS_H);
   assign rem    = hash_ff - quot_n;

   assign rd_mark  = rd_data_ff[ENTRY_W-1 -: MARK_W];
   assign rd_key   = rd_data_ff[VALUE_BITS +: KW];
   assign rd_value = rd_data_ff[VALUE_BITS-1:0];

   assign eval       = cmd.probe && rd_valid_ff;
   assign is_empty   = (rd_mark == MARK_EMPTY);
   assign is_match   = (rd_mark == MARK_LIVE) && (rd_key == key_ff);
   assign is_tomb    = (rd_mark == MARK_TOMB);
   assign probe_done = eval && (is_empty || is_match || (cnt_ff == LAST_CNT));
   assign sweep_done = cmd.sweep && (addr_ff == LAST_IDX);
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign fin_go     = cmd.finish && rsp_free;

   assign sts.req_clear  = (req_operation == OP_CLEAR);
   assign sts.probe_done = probe_done;
   assign sts.sweep_done = sweep_done;
   assign sts.rsp_free   = rsp_free;

   always_comb begin
      res_hit    = 1'b0;
      res_value  = '0;
      res_status = ST_OK;
      res_wr     = 1'b0;
      res_mark   = MARK_LIVE;
      res_bump   = 1'b0;
      if (op_ff == OP_SET) begin
         if (!found_ff) begin
            res_status = ST_FULL;
         end else begin
            case (kind_ff)
               MARK_LIVE: res_wr = 1'b1;
               MARK_EMPTY: begin
                  if (used_ff >= {1'b0, limit_ff}) begin
                     res_status = ST_FULL;
                  end else begin
                     res_wr   = 1'b1;
                     res_bump = 1'b1;
                     res_hit  = 1'b1;
                  end
               end
               default: begin
                  res_wr  = 1'b1;
                  res_hit = 1'b1;
               end
            endcase
         end
      end else if (op_ff inside {OP_GET, OP_DEL}) begin
         if (found_ff && (kind_ff == MARK_LIVE)) begin
            res_hit = 1'b1;
            if (op_ff == OP_GET) begin
               res_value = VALUE_W'(hit_val_ff);
            end else begin
               res_wr   = 1'b1;
               res_mark = MARK_TOMB;
            end
         end else begin
            res_status = ST_MISS;
         end
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.capture) begin
         addr_in = '0;
      end else if (cmd.mod_sub) begin
         addr_in = rem[IDX_W-1:0];
      end else if (cmd.probe || cmd.sweep) begin
         addr_in = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
      end
   end

   assign mem_we = cmd.sweep || (fin_go && res_wr);
   assign mem_wa = cmd.sweep ? addr_ff : slot_ff;
   assign mem_wd = cmd.sweep ? {MARK_EMPTY, {(KW + VALUE_BITS){1'b0}}}
                             : {res_mark, key_ff, val_ff};

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[addr_ff];
      rd_idx_ff  <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         key_ff  <= req_key_id[KW-1:0];
         hash_ff <= req_key_hash;
         val_ff  <= req_value_in[VALUE_BITS-1:0];
      end
      if (cmd.mod_mul) prod_ff <= PROD_W'(hash_ff) * PROD_W'(RECIP[HASH_W:0]);
      if (cmd.mod_sub) begin
         cnt_ff       <= '0;
         have_tomb_ff <= 1'b0;
      end else if (eval) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (is_tomb && !have_tomb_ff) begin
            have_tomb_ff <= 1'b1;
            tomb_ff      <= rd_idx_ff;
         end
      end
      if (probe_done) begin
         hit_val_ff <= rd_value;
         if (is_match) begin
            found_ff <= 1'b1;
            slot_ff  <= rd_idx_ff;
            kind_ff  <= MARK_LIVE;
         end else if (is_empty) begin
            found_ff <= 1'b1;
            slot_ff  <= have_tomb_ff ? tomb_ff : rd_idx_ff;
            kind_ff  <= have_tomb_ff ? MARK_TOMB : MARK_EMPTY;
         end else begin
            found_ff <= have_tomb_ff || is_tomb;
            slot_ff  <= have_tomb_ff ? tomb_ff : rd_idx_ff;
            kind_ff  <= MARK_TOMB;
         end
      end
      if (fin_go) begin
         rsp_hit_ff    <= res_hit;
         rsp_value_ff  <= res_value;
         rsp_status_ff <= res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         used_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         rd_valid_ff <= cmd.probe && !probe_done;
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (sweep_done) begin
            used_ff <= '0;
         end else if (fin_go && res_bump) begin
            used_ff <= used_ff + 1'b1;
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hit       = rsp_hit_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule

[hdl/open_addressing_hash_table.sv]
// Top level of the open-addressing key/value table with linear probing and tombstones.
//
//   Channel   Direction  Handshake        Carries
//   req_chan  in         valid / ready    operation, key_id, key_hash, value_in
//   rsp_chan  out        valid / ready    hit, value_out, status
//   csr_*     in         csr_wr_en        load_limit
//
// A get, set or delete passes through capture, hash reduction, probing and finish before the
// next acceptance; the single read port of the slot memory examines one slot per cycle.
// A clear sweeps the whole table, one slot written per cycle.
// After reset the memory is wiped before the first request is taken.
// One request is in flight at a time; a waiting response stalls only the completion
// of the next request, which is accepted meanwhile.
`timescale 1ns / 1ps

module open_addressing_hash_table import oaht_pkg::*; #(
   parameter int TABLE_SLOTS = 256,
   parameter int KEY_BITS    = 32,
   parameter int VALUE_BITS  = 64
) (
   input  logic               clock,
   input  logic               reset,
   oaht_req_if.sink           req_chan,
   oaht_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic         req_ready;

   assign req_chan.ready = req_ready;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oaht_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_chan.operation),
      .req_key_id    (req_chan.key_id),
      .req_key_hash  (req_chan.key_hash),
      .req_value_in  (req_chan.value_in),
      .rsp_chan      (rsp_chan),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .sts           (sts)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("request accepted while another request is in flight");

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.finish))
      else $error("response raised without a finishing request");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mod_mul, cmd.mod_sub, cmd.probe, cmd.sweep, cmd.finish}))
      else $error("controller issued more than one command");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.hit) |-> (rsp_chan.status == ST_OK))
      else $error("hit reported with a non-ok status");

endmodule

[tb/oaht_checker.sv]
// Checker that mirrors the hash table contents and compares every response with its prediction.
`timescale 1ns / 1ps

module oaht_checker import oaht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   oaht_req_if                req_mon,
   oaht_rsp_if                rsp_mon,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data,
   output int                 mismatch_count,
   output int                 answers_due
);

   localparam int SLOTS     = 256;
   localparam int SLOT_BITS = 8;

   typedef struct packed {
      logic                hit;
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } answer_type;

   logic [MARK_W-1:0]   slot_mark  [SLOTS];
   logic [KEY_ID_W-1:0] slot_key   [SLOTS];
   logic [VALUE_W-1:0]  slot_value [SLOTS];
   logic [USED_W-1:0]   used_slots;
   logic [LIMIT_W-1:0]  load_limit;
   answer_type          pending_answers [$];
   int                  errors = 0;

   // Linear probe from the hashed slot. It stops on a live slot with the same key or on a
   // never-used slot, and in the latter case prefers the first tombstone passed.
   function automatic bit find_slot(input logic [KEY_ID_W-1:0] key,
                                    input logic [HASH_W-1:0] hash, output int slot);
      int  idx;
      int  tomb;
      int  n;
      bit  seen_tomb;
      idx       = int'(hash[SLOT_BITS-1:0]);
      tomb      = 0;
      seen_tomb = 1'b0;
      slot      = 0;
      for (n = 0; n < SLOTS; n++) begin
         if (slot_mark[idx] == MARK_EMPTY) begin
            slot = seen_tomb ? tomb : idx;
            return 1'b1;
         end
         if (slot_mark[idx] == MARK_LIVE) begin
            if (slot_key[idx] == key) begin
               slot = idx;
               return 1'b1;
            end
         end else if (!seen_tomb) begin
            seen_tomb = 1'b1;
            tomb      = idx;
         end
         idx = (idx + 1) % SLOTS;
      end
      slot = tomb;
      return seen_tomb;
   endfunction

   // Applies one request to the mirrored table and returns the response it must produce.
   function automatic answer_type apply_request(input logic [OP_W-1:0] op,
                                                input logic [KEY_ID_W-1:0] key,
                                                input logic [HASH_W-1:0] hash,
                                                input logic [VALUE_W-1:0] value);
      answer_type ans;
      int         slot;
      bit         found;
      int         i;
      ans = '{hit: 1'b0, value: '0, status: ST_OK};
      case (op)
         OP_CLEAR: begin
            for (i = 0; i < SLOTS; i++) slot_mark[i] = MARK_EMPTY;
            used_slots = '0;
         end
         OP_SET: begin
            found = find_slot(key, hash, slot);
            if (!found) begin
               ans.status = ST_FULL;
            end else if (slot_mark[slot] == MARK_LIVE) begin
               slot_value[slot] = value;
            end else if (slot_mark[slot] == MARK_EMPTY && used_slots >= load_limit) begin
               ans.status = ST_FULL;
            end else begin
               if (slot_mark[slot] == MARK_EMPTY) used_slots = used_slots + 1'b1;
               slot_mark[slot]  = MARK_LIVE;
               slot_key[slot]   = key;
               slot_value[slot] = value;
               ans.hit          = 1'b1;
            end
         end
         default: begin
            found = 1'b0;
            if (used_slots != 0) found = find_slot(key, hash, slot);
            if (found && slot_mark[slot] == MARK_LIVE) begin
               ans.hit = 1'b1;
               if (op == OP_GET) ans.value = slot_value[slot];
               else slot_mark[slot] = MARK_TOMB;
            end else begin
               ans.status = ST_MISS;
            end
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      answer_type got;
      int         i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++) slot_mark[i] = MARK_EMPTY;
         used_slots = '0;
         load_limit = LIMIT_RESET;
         pending_answers.delete();
      end else begin
         if (csr_wr_en) load_limit = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.hit    = rsp_mon.hit;
            got.value  = rsp_mon.value_out;
            got.status = rsp_mon.status;
            if (pending_answers.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with no request waiting: hit %0b value %h status %0d",
                           $time, got.hit, got.value, got.status);
            end else begin
               want = pending_answers.pop_front();
               if (got.hit !== want.hit || got.value !== want.value ||
                   got.status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: hit %0b/%0b value %h/%h status %0d/%0d %s",
                              $time, want.hit, got.hit, want.value, got.value,
                              want.status, got.status, "(expected/actual)");
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_answers.push_back(apply_request(req_mon.operation, req_mon.key_id,
                                                    req_mon.key_hash, req_mon.value_in));
      end
      answers_due    <= pending_answers.size();
      mismatch_count <= errors;
   end

endmodule

[tb/tb.sv]
// Top of the hash table testbench: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module tb;
   import oaht_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;
   int                 mismatch_count;
   int                 answers_due;
   logic               calm;
   int                 rsp_hold = 0;
   int                 items_sent = 0;

   oaht_req_if req_chan ();
   oaht_rsp_if rsp_chan ();

   open_addressing_hash_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   oaht_checker table_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .answers_due    (answers_due)
   );

   always #4 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold       <= 0;
      end else if (calm) begin
         rsp_chan.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_chan.ready) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold       <= gap_len();
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_hold       <= $urandom_range(0, 30);
      end
   end

   task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_ID_W-1:0] key,
                           input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] value);
      int gap;
      gap = calm ? 0 : gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.key_id    <= key;
      req_chan.key_hash  <= hash;
      req_chan.value_in  <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (answers_due != 0);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [KEY_ID_W-1:0] pool_key  [256];
      logic [HASH_W-1:0]   pool_hash [256];
      logic [LIMIT_W-1:0]  limit;
      logic [7:0]          base;
      logic [VALUE_W-1:0]  value;
      int                  pool_size;
      int                  spread;
      int                  set_pct;
      int                  length;
      int                  start;
      int                  phase;
      int                  r;
      int                  i;
      bit                  big;

      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      calm               <= 1'b0;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_GET;
      req_chan.key_id    <= '0;
      req_chan.key_hash  <= '0;
      req_chan.value_in  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty table, collisions that wrap past the last slot, overwrite, tombstones and key zero.
      send_req(OP_GET,   32'h0000_1234, 32'h0000_0010, '0);
      send_req(OP_DEL,   32'h0000_1234, 32'h0000_0010, '0);
      send_req(OP_SET,   32'hA5A5_0001, 32'hFFFF_FFFF, '1);
      send_req(OP_SET,   32'h5A5A_0002, 32'h0000_00FF, '0);
      send_req(OP_GET,   32'hA5A5_0001, 32'hFFFF_FFFF, '0);
      send_req(OP_GET,   32'h5A5A_0002, 32'h0000_00FF, '0);
      send_req(OP_SET,   32'hA5A5_0001, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
      send_req(OP_GET,   32'hA5A5_0001, 32'hFFFF_FFFF, '0);
      send_req(OP_DEL,   32'hA5A5_0001, 32'hFFFF_FFFF, '0);
      send_req(OP_GET,   32'h5A5A_0002, 32'h0000_00FF, '0);
      send_req(OP_DEL,   32'hA5A5_0001, 32'hFFFF_FFFF, '0);
      send_req(OP_SET,   32'hFFFF_FFFF, 32'h8000_00FF, 64'hFEDC_BA98_7654_3210);
      send_req(OP_GET,   32'hFFFF_FFFF, 32'h8000_00FF, '0);
      send_req(OP_SET,   32'h0000_0000, 32'h0000_0000, 64'h8000_0000_0000_0001);
      send_req(OP_GET,   32'h0000_0000, 32'h0000_0000, '0);
      send_req(OP_GET,   32'hA5A5_0001, 32'h0000_007F, '0);
      send_req(OP_CLEAR, 32'h0000_0000, 32'h0000_0000, '0);
      send_req(OP_GET,   32'h5A5A_0002, 32'h0000_00FF, '0);
      drain();

      // Load limit of one: refusals, overwrite of a live key and reuse of a tombstone.
      write_limit(8'd1);
      send_req(OP_SET,   32'h0000_00D1, 32'h0000_0040, 64'h1);
      send_req(OP_SET,   32'h0000_00E1, 32'h0000_0041, 64'h2);
      send_req(OP_SET,   32'h0000_00D1, 32'h0000_0040, 64'h3);
      send_req(OP_DEL,   32'h0000_00D1, 32'h0000_0040, '0);
      send_req(OP_SET,   32'h0000_00E1, 32'h0000_0040, 64'h4);
      send_req(OP_SET,   32'h0000_00F1, 32'h0000_0080, 64'h5);
      send_req(OP_GET,   32'h0000_00E1, 32'h0000_0040, '0);
      send_req(OP_CLEAR, 32'h0000_0000, 32'h0000_0000, '0);

      phase = 0;
      start = items_sent;
      while (items_sent - start < 2000) begin
         calm <= ($urandom_range(0, 3) == 0);
         drain();
         case (phase % 7)
            0:       limit = 8'd255;
            1:       limit = 8'd1;
            2:       limit = LIMIT_W'($urandom_range(2, 16));
            3:       limit = LIMIT_RESET;
            4:       limit = LIMIT_W'($urandom_range(1, 255));
            5:       limit = 8'd254;
            default: limit = LIMIT_W'($urandom_range(32, 128));
         endcase
         write_limit(limit);
         phase++;

         big = ($urandom_range(0, 3) == 0);
         pool_size = big ? $urandom_range(100, 250) : $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 3;
            2:       spread = 15;
            default: spread = 255;
         endcase
         base = 8'($urandom_range(0, 255));
         for (i = 0; i < pool_size; i++) begin
            pool_key[i]       = $urandom;
            pool_hash[i]      = $urandom;
            pool_hash[i][7:0] = 8'(base + $urandom_range(0, spread));
         end
         set_pct = $urandom_range(25, 70);
         length  = big ? $urandom_range(150, 400) : $urandom_range(30, 150);

         if ($urandom_range(0, 1)) send_req(OP_CLEAR, $urandom, $urandom, {$urandom, $urandom});
         repeat (length) begin
            r     = $urandom_range(0, 99);
            i     = $urandom_range(0, pool_size - 1);
            value = {$urandom, $urandom};
            if (r < set_pct)
               send_req(OP_SET, pool_key[i], pool_hash[i], value);
            else if (r < set_pct + (100 - set_pct) / 2)
               send_req(OP_GET, pool_key[i], pool_hash[i], value);
            else if (r < 94)
               send_req(OP_DEL, pool_key[i], pool_hash[i], value);
            else if (r < 96)
               send_req(OP_CLEAR, $urandom, $urandom, value);
            else if (r < 98)
               send_req(OP_W'($urandom_range(OP_GET, OP_DEL)), $urandom, pool_hash[i], value);
            else
               send_req(OP_W'($urandom_range(OP_GET, OP_DEL)), pool_key[i], $urandom, value);
         end
      end

      drain();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** open_addressing_hash_table: PASSED **");
      end else begin
         $display("** open_addressing_hash_table: FAILED **");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("** open_addressing_hash_table: FAILED **");
      $finish;
   end

endmodule
